// ===== rtl/lpcp_pkg.sv =====
// ----------------------------------------------------------------------------
// lpcp_pkg
// Shared types and constants for the lidar point to camera projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcp_pkg;

	// Width of the exact row arithmetic (products, sums, remainders).
	localparam int ROW_W = 64;
	// Quotient magnitude width; larger quotients saturate.
	localparam int QUO_W = 40;
	localparam logic [QUO_W-1:0] QCAP = '1;
	// Width of the u and v output fields.
	localparam int POS_W = 30;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	// Configuration port.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int FRAME_W = 28;
	localparam int DIM_W = 14;
	localparam int MAXD_W = 31;
	localparam logic [FRAME_W-1:0] FRAME_RST = 28'd11797760;
	localparam logic [MAXD_W-1:0] MAXD_RST = 31'd3276800;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_R0_AB = 3'd0,
		REG_R0_CD = 3'd1,
		REG_R1_AB = 3'd2,
		REG_R1_CD = 3'd3,
		REG_R2_AB = 3'd4,
		REG_R2_CD = 3'd5,
		REG_FRAME = 3'd6,
		REG_MAXD  = 3'd7
	} cfg_idx_t;

	// Per-item flags that travel along the divider stages.
	typedef struct packed {
		logic              wnz;
		logic              depth_ok;
		logic              neg_u;
		logic              neg_v;
		logic              sat_u;
		logic              sat_v;
		logic signed [31:0] depth;
	} dctl_t;

endpackage

`default_nettype wire

// ===== rtl/lidar_point_camera_projection.sv =====
// Registers from an accepted point to its result: products, row sums,
// magnitudes, saturation test, 40 restoring divider stages, output register.
// Throughput: one point per cycle; the whole pipeline holds while a result waits.
// The divider produces one quotient bit per stage for both u and v.
// Reset clears all valid bits and loads the configuration reset values.
// ----------------------------------------------------------------------------
// lidar_point_camera_projection
// Projects a lidar point through a 3x4 fixed-point camera matrix, divides by
// depth and tests the pixel position against the framed border and depth limit.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_camera_projection #(
	parameter int MARGIN = 100,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [lpcp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lpcp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [31:0]                 point_x,
	input  wire logic signed [31:0]                 point_y,
	input  wire logic signed [31:0]                 point_z,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    accepted,
	output logic [lpcp_pkg::POS_W-1:0]              u_pos,
	output logic [lpcp_pkg::POS_W-1:0]              v_pos,
	output logic signed [31:0]                      depth
);
	import lpcp_pkg::*;

	localparam int DIV_N = QUO_W;
	localparam int HI_SH = QUO_W - FRAC_BITS;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] proj_q [6];
	logic [FRAME_W-1:0]    frame_q;
	logic [MAXD_W-1:0]     maxd_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) proj_q[i] <= '0;
			frame_q <= FRAME_RST;
			maxd_q <= MAXD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_R0_AB: proj_q[0] <= cfg_data;
				REG_R0_CD: proj_q[1] <= cfg_data;
				REG_R1_AB: proj_q[2] <= cfg_data;
				REG_R1_CD: proj_q[3] <= cfg_data;
				REG_R2_AB: proj_q[4] <= cfg_data;
				REG_R2_CD: proj_q[5] <= cfg_data;
				REG_FRAME: frame_q <= cfg_data[FRAME_W-1:0];
				REG_MAXD:  maxd_q <= cfg_data[MAXD_W-1:0];
				default:   ;
			endcase
		end
	end

	// The whole pipeline moves unless a finished result is held back.
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 1: nine coefficient by coordinate products.
	logic                    v_s1;
	logic signed [ROW_W-1:0] prod_s1 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[3*r]   <= $signed(proj_q[2*r][31:0]) * point_x;
				prod_s1[3*r+1] <= $signed(proj_q[2*r][63:32]) * point_y;
				prod_s1[3*r+2] <= $signed(proj_q[2*r+1][31:0]) * point_z;
			end
		end
	end

	// Stage 2: floor-shifted products summed with the translation term.
	logic                    v_s2;
	logic signed [ROW_W-1:0] row_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				row_s2[r] <= (prod_s1[3*r] >>> FRAC_BITS) + (prod_s1[3*r+1] >>> FRAC_BITS)
					+ (prod_s1[3*r+2] >>> FRAC_BITS)
					+ ROW_W'($signed(proj_q[2*r+1][63:32]));
			end
		end
	end

	// Stage 3: magnitudes, quotient signs, depth limit and saturated depth.
	logic             v_s3;
	logic [ROW_W-1:0] absu_s3, absv_s3, absw_s3;
	dctl_t            ctl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			absu_s3 <= row_s2[0][ROW_W-1] ? -row_s2[0] : row_s2[0];
			absv_s3 <= row_s2[1][ROW_W-1] ? -row_s2[1] : row_s2[1];
			absw_s3 <= row_s2[2][ROW_W-1] ? -row_s2[2] : row_s2[2];
			ctl_s3.wnz <= (row_s2[2] != '0);
			ctl_s3.depth_ok <= (row_s2[2] <= $signed(ROW_W'(maxd_q)));
			ctl_s3.neg_u <= row_s2[0][ROW_W-1] ^ row_s2[2][ROW_W-1];
			ctl_s3.neg_v <= row_s2[1][ROW_W-1] ^ row_s2[2][ROW_W-1];
			ctl_s3.sat_u <= 1'b0;
			ctl_s3.sat_v <= 1'b0;
			ctl_s3.depth <= (row_s2[2] < -(ROW_W'(64'sh80000000))) ? 32'sh80000000
				: row_s2[2][31:0];
		end
	end

	// Stage 4: saturation test and divider setup.
	logic             dv_v_s  [DIV_N+1];
	dctl_t            dv_c_s  [DIV_N+1];
	logic [ROW_W-1:0] dv_den_s [DIV_N+1];
	logic [ROW_W-1:0] dv_ru_s [DIV_N+1];
	logic [ROW_W-1:0] dv_rv_s [DIV_N+1];
	logic [QUO_W-1:0] dv_lu_s [DIV_N+1];
	logic [QUO_W-1:0] dv_lv_s [DIV_N+1];
	logic [QUO_W-1:0] dv_qu_s [DIV_N+1];
	logic [QUO_W-1:0] dv_qv_s [DIV_N+1];

	logic [2*ROW_W-1:0] den_wide;
	assign den_wide = (2*ROW_W)'(absw_s3) << HI_SH;

	// A quotient saturates when its integer part does not fit the quotient width.
	dctl_t ctl_set;
	always_comb begin
		ctl_set = ctl_s3;
		ctl_set.sat_u = (2*ROW_W)'(absu_s3) >= den_wide;
		ctl_set.sat_v = (2*ROW_W)'(absv_s3) >= den_wide;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (adv) dv_v_s[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_c_s[0] <= ctl_set;
			dv_den_s[0] <= absw_s3;
			dv_ru_s[0] <= absu_s3 >> HI_SH;
			dv_rv_s[0] <= absv_s3 >> HI_SH;
			dv_lu_s[0] <= QUO_W'(absu_s3 << FRAC_BITS);
			dv_lv_s[0] <= QUO_W'(absv_s3 << FRAC_BITS);
			dv_qu_s[0] <= '0;
			dv_qv_s[0] <= '0;
		end
	end

	// Divider stages: one restoring step for u and for v in each stage.
	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic [ROW_W-1:0] tu, tv;
		logic             geu, gev;

		assign tu = {dv_ru_s[k][ROW_W-2:0], dv_lu_s[k][QUO_W-1]};
		assign tv = {dv_rv_s[k][ROW_W-2:0], dv_lv_s[k][QUO_W-1]};
		assign geu = tu >= dv_den_s[k];
		assign gev = tv >= dv_den_s[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k+1] <= 1'b0;
			else if (adv) dv_v_s[k+1] <= dv_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_c_s[k+1] <= dv_c_s[k];
				dv_den_s[k+1] <= dv_den_s[k];
				dv_ru_s[k+1] <= geu ? tu - dv_den_s[k] : tu;
				dv_rv_s[k+1] <= gev ? tv - dv_den_s[k] : tv;
				dv_lu_s[k+1] <= dv_lu_s[k] << 1;
				dv_lv_s[k+1] <= dv_lv_s[k] << 1;
				dv_qu_s[k+1] <= {dv_qu_s[k][QUO_W-2:0], geu};
				dv_qv_s[k+1] <= {dv_qv_s[k][QUO_W-2:0], gev};
			end
		end
	end

	// Final decision: frame bounds, depth limit and output saturation.
	dctl_t                   fc;
	logic [QUO_W-1:0]        qu, qv;
	logic signed [ROW_W-1:0] su, sv, lo, hi_u, hi_v;
	logic                    ok;

	always_comb begin
		fc = dv_c_s[DIV_N];
		qu = fc.sat_u ? QCAP : dv_qu_s[DIV_N];
		qv = fc.sat_v ? QCAP : dv_qv_s[DIV_N];
		su = fc.neg_u ? -$signed(ROW_W'(qu)) : $signed(ROW_W'(qu));
		sv = fc.neg_v ? -$signed(ROW_W'(qv)) : $signed(ROW_W'(qv));
		lo = $signed(ROW_W'(MARGIN)) <<< FRAC_BITS;
		hi_u = ($signed(ROW_W'(frame_q[DIM_W-1:0])) - $signed(ROW_W'(MARGIN))) <<< FRAC_BITS;
		hi_v = ($signed(ROW_W'(frame_q[2*DIM_W-1:DIM_W])) - $signed(ROW_W'(MARGIN)))
			<<< FRAC_BITS;
		ok = fc.wnz && fc.depth_ok && (su >= lo) && (su <= hi_u) && (sv >= lo) && (sv <= hi_v);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= dv_v_s[DIV_N];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accepted <= ok;
			u_pos <= !ok ? '0 : (qu > QUO_W'(POS_MAX)) ? POS_MAX : qu[POS_W-1:0];
			v_pos <= !ok ? '0 : (qv > QUO_W'(POS_MAX)) ? POS_MAX : qv[POS_W-1:0];
			depth <= ok ? fc.depth : '0;
		end
	end

endmodule

`default_nettype wire

// ===== verif/lidar_point_camera_projection_chk.sv =====
// ----------------------------------------------------------------------------
// Projection result checker
// Watches the configuration, point and result channels of the projection
// block. It keeps its own copy of the matrix and frame registers and works out
// each result when a point item is accepted. Each result item is then checked
// field by field against the oldest expected result.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_camera_projection_chk #(
	parameter int MARGIN = 100,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	input  wire logic                              cfg_ready,
	input  wire logic [lpcp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lpcp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic signed [31:0]                point_x,
	input  wire logic signed [31:0]                point_y,
	input  wire logic signed [31:0]                point_z,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic                              accepted,
	input  wire logic [lpcp_pkg::POS_W-1:0]        u_pos,
	input  wire logic [lpcp_pkg::POS_W-1:0]        v_pos,
	input  wire logic signed [31:0]                depth,
	output int                                     fail_count,
	output int                                     pending,
	output int                                     n_results,
	output int                                     n_hits
);
	import lpcp_pkg::*;

	typedef struct packed {
		logic               hit;
		logic [POS_W-1:0]   u;
		logic [POS_W-1:0]   v;
		logic signed [31:0] d;
	} pixel_t;

	pixel_t            pixel_q[$];
	logic [63:0]       mat_reg [6];
	logic [FRAME_W-1:0] frame_reg;
	logic [MAXD_W-1:0] maxd_reg;

	initial begin
		fail_count = 0;
		pending = 0;
		n_results = 0;
		n_hits = 0;
	end

	// One matrix row dotted with the point, each product floored to the grid.
	function automatic longint row_dot(int r, longint x, longint y, longint z);
		logic [63:0] ab;
		logic [63:0] cd;
		longint a, b, c, d;
		ab = mat_reg[2*r];
		cd = mat_reg[2*r+1];
		a = longint'(signed'(ab[31:0]));
		b = longint'(signed'(ab[63:32]));
		c = longint'(signed'(cd[31:0]));
		d = longint'(signed'(cd[63:32]));
		return ((a * x) >>> FRAC_BITS) + ((b * y) >>> FRAC_BITS) +
			((c * z) >>> FRAC_BITS) + d;
	endfunction

	// Fixed-point quotient truncated toward zero with a capped magnitude.
	function automatic longint fx_quot(longint n, longint w);
		logic [127:0] un, ud, q;
		logic neg;
		neg = (n < 0) != (w < 0);
		un = (n < 0) ? -n : n;
		ud = (w < 0) ? -w : w;
		q = (un << FRAC_BITS) / ud;
		if (q > QCAP)
			q = QCAP;
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic pixel_t project(longint x, longint y, longint z);
		pixel_t res;
		longint nu, nv, w, u, v, lo, hi_u, hi_v;
		res = '0;
		nu = row_dot(0, x, y, z);
		nv = row_dot(1, x, y, z);
		w = row_dot(2, x, y, z);
		if (w != 0) begin
			u = fx_quot(nu, w);
			v = fx_quot(nv, w);
			lo = longint'(MARGIN) <<< FRAC_BITS;
			hi_u = (longint'(frame_reg[DIM_W-1:0]) - MARGIN) <<< FRAC_BITS;
			hi_v = (longint'(frame_reg[2*DIM_W-1:DIM_W]) - MARGIN) <<< FRAC_BITS;
			if (u >= lo && u <= hi_u && v >= lo && v <= hi_v &&
					w <= longint'(maxd_reg)) begin
				res.hit = 1'b1;
				res.u = (u > longint'(POS_MAX)) ? POS_MAX : u[POS_W-1:0];
				res.v = (v > longint'(POS_MAX)) ? POS_MAX : v[POS_W-1:0];
				res.d = (w < -64'sd2147483648) ? 32'sh80000000 : w[31:0];
			end
		end
		return res;
	endfunction

	// Register shadow, prediction on point items and comparison on result items.
	always @(posedge clk or negedge arst_n) begin
		pixel_t exp_px;
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				mat_reg[i] <= '0;
			frame_reg <= FRAME_RST;
			maxd_reg <= MAXD_RST;
			pixel_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					REG_FRAME: begin
						frame_reg <= cfg_data[FRAME_W-1:0];
					end
					REG_MAXD: begin
						maxd_reg <= cfg_data[MAXD_W-1:0];
					end
					default: begin
						mat_reg[cfg_index] <= cfg_data;
					end
				endcase
			end
			if (in_valid && !in_stall)
				pixel_q = {pixel_q, project(point_x, point_y, point_z)};
			if (out_valid && !out_stall) begin
				n_results <= n_results + 1;
				if (accepted)
					n_hits <= n_hits + 1;
				if (pixel_q.size() == 0) begin
					$display("%0t: result item with no point pending", $time);
					fail_count <= fail_count + 1;
				end else begin
					exp_px = pixel_q.pop_front();
					if (exp_px.hit !== accepted || exp_px.u !== u_pos ||
							exp_px.v !== v_pos || exp_px.d !== depth) begin
						$display("%0t: mismatch expected acc=%0b u=%h v=%h d=%h", $time,
							exp_px.hit, exp_px.u, exp_px.v, exp_px.d);
						$display("%0t:            actual acc=%0b u=%h v=%h d=%h", $time,
							accepted, u_pos, v_pos, depth);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= pixel_q.size();
		end
	end

endmodule

`default_nettype wire

// ===== verif/lidar_point_camera_projection_tb.sv =====
// ----------------------------------------------------------------------------
// Projection block testbench
// Loads a series of camera matrices, frame sizes and depth limits, drives
// directed edge points and random points under varied idle and stall
// patterns, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_camera_projection_tb;
	import lpcp_pkg::*;

	localparam int ONE = 1 << 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic signed [31:0]     point_x = '0;
	logic signed [31:0]     point_y = '0;
	logic signed [31:0]     point_z = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   accepted;
	logic [POS_W-1:0]       u_pos;
	logic [POS_W-1:0]       v_pos;
	logic signed [31:0]     depth;

	int fail_count, pending, n_results, n_hits;
	int tx_pct = 0;
	int rx_pct = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int n_settings = 0;
	int hold_reqs = 0;
	int hold_seen = 0;

	lidar_point_camera_projection dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.accepted(accepted), .u_pos(u_pos), .v_pos(v_pos), .depth(depth)
	);

	lidar_point_camera_projection_chk chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.accepted(accepted), .u_pos(u_pos), .v_pos(v_pos), .depth(depth),
		.fail_count(fail_count), .pending(pending),
		.n_results(n_results), .n_hits(n_hits)
	);

	always #4 clk = ~clk;

	// Result side: random stalls, plus a long hold-off when requested.
	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_pct);
		end
	end

	// Watchdog on cycles without any accepted item.
	always @(posedge clk) begin
		if (arst_n && !(cfg_valid && cfg_ready) && !(in_valid && !in_stall) &&
				!(out_valid && !out_stall)) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("lidar_point_camera_projection_tb failed");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	function automatic logic [63:0] pack2(int lo, int hi);
		return {hi, lo};
	endfunction

	function automatic logic [63:0] frame_of(int w, int h);
		return 64'((h << DIM_W) | w);
	endfunction

	// Leaves valid high at the following falling edge.
	task automatic cfg_put(cfg_idx_t idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_setup(logic [63:0] r0ab, r0cd, r1ab, r1cd, r2ab, r2cd,
			logic [63:0] frame, maxd);
		cfg_put(REG_R0_AB, r0ab);
		cfg_put(REG_R0_CD, r0cd);
		cfg_put(REG_R1_AB, r1ab);
		cfg_put(REG_R1_CD, r1cd);
		cfg_put(REG_R2_AB, r2ab);
		cfg_put(REG_R2_CD, r2cd);
		cfg_put(REG_FRAME, frame);
		cfg_put(REG_MAXD, maxd);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// Pinhole camera looking down +z; sgn = -1 flips the whole matrix.
	task automatic load_camera(int fx, int fy, int cx, int cy, int sgn,
			logic [63:0] frame, maxd);
		load_setup(pack2(sgn * fx, 0), pack2(sgn * cx, 0), pack2(0, sgn * fy),
			pack2(sgn * cy, 0), 64'd0, pack2(sgn * ONE, 0), frame, maxd);
	endtask

	task automatic push_point(int x, int y, int z);
		if ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < tx_pct);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Sender waits for every result, then lets the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (60) @(negedge clk);
	endtask

	// Plausible scene points at the given percentage, the rest noise over the full range.
	task automatic rand_points(int n, int camera_pct);
		int x, y, z;
		for (int k = 0; k < n; k++) begin
			case ((k / 40) % 5)
				1: begin tx_pct = 65; rx_pct = 0; end
				2: begin tx_pct = 0; rx_pct = 65; end
				3: begin tx_pct = 16; rx_pct = 16; end
				default: begin tx_pct = 0; rx_pct = 0; end
			endcase
			if ($urandom_range(99) < camera_pct) begin
				x = int'($urandom_range(40 * ONE)) - 20 * ONE;
				y = int'($urandom_range(40 * ONE)) - 20 * ONE;
				z = int'($urandom_range(60 * ONE, ONE / 4));
				if ($urandom_range(9) == 0)
					z = -z;
			end else begin
				x = $urandom;
				y = $urandom;
				z = $urandom;
			end
			push_point(x, y, z);
		end
		tx_pct = 0;
		rx_pct = 0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset matrix is all zero, so depth is zero and every point is rejected.
		push_point(0, 0, 0);
		push_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		push_point(32'h80000000, 32'h80000000, 32'h80000000);
		rand_points(40, 50);
		drain();

		// Unit matrix with offsets that put the origin on the frame corner.
		load_setup(pack2(ONE, 0), pack2(100 * ONE, 0), pack2(0, ONE),
			pack2(100 * ONE, 0), 64'd0, pack2(ONE, 0), frame_of(1280, 720),
			64'(50 * ONE));
		push_point(0, 0, ONE);
		push_point(-1, 0, ONE);
		push_point(1080 * ONE, 520 * ONE, ONE);
		push_point(1080 * ONE + 1, 0, ONE);
		push_point(0, 520 * ONE + 1, ONE);
		push_point(0, 0, 50 * ONE);
		push_point(0, 0, 50 * ONE + 1);
		push_point(0, 0, 0);
		rand_points(150, 80);
		drain();

		// Typical camera; the receiver holds off long enough to fill the pipe.
		load_camera(500 * ONE, 500 * ONE, 640 * ONE, 360 * ONE, 1,
			frame_of(1280, 720), 64'(50 * ONE));
		push_point(0, 0, 10 * ONE);
		rand_points(200, 85);
		hold_reqs++;
		rand_points(200, 85);
		drain();

		// Negated matrix: points in front give negative depth and still pass.
		load_camera(500 * ONE, 500 * ONE, 640 * ONE, 360 * ONE, -1,
			frame_of(1280, 720), 64'd0);
		push_point(0, 0, 10 * ONE);
		rand_points(300, 85);
		drain();

		// Depth far below the 32-bit range saturates on an accepted point.
		load_setup(pack2(32'h80000000, 0), 64'd0, pack2(0, 32'h80000000), 64'd0,
			64'd0, pack2(32'hffff0000, 32'h80000000), frame_of(1280, 720),
			64'(50 * ONE));
		push_point(500 * ONE, 300 * ONE, ONE);
		push_point(500 * ONE, 300 * ONE, 32'h80000000);
		rand_points(100, 30);
		drain();

		// Full-range matrix, largest frame and depth limit, junk in unused bits.
		load_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom} | 64'hfffffff, 64'hffffffff_ffffffff);
		push_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
		push_point(32'h80000000, 32'h7fffffff, 32'h80000000);
		push_point(0, 0, 1);
		rand_points(250, 40);
		drain();

		// Empty frame and zero depth limit reject everything.
		load_camera(500 * ONE, 500 * ONE, 640 * ONE, 360 * ONE, 1, 64'd0, 64'd0);
		rand_points(150, 85);
		drain();

		// Frame narrower than twice the border.
		load_camera(100 * ONE, 100 * ONE, 75 * ONE, 75 * ONE, 1,
			frame_of(150, 150), 64'($urandom));
		rand_points(80, 85);
		drain();

		// Random cameras on random frames.
		for (int s = 0; s < 2; s++) begin
			load_camera(int'($urandom_range(2000, 50)) * ONE,
				int'($urandom_range(2000, 50)) * ONE,
				int'($urandom_range(1000, 150)) * ONE,
				int'($urandom_range(1000, 150)) * ONE, 1,
				frame_of($urandom_range(2000, 300), $urandom_range(2000, 300)),
				64'($urandom_range(60 * ONE, 10 * ONE)));
			rand_points(150, 85);
			drain();
		end

		$display("%0d results checked, %0d points accepted by the block", n_results,
			n_hits);
		$display("%0d register setups, including empty frames and saturated depth",
			n_settings);
		if (fail_count == 0 && pending == 0) begin
			$display("lidar_point_camera_projection_tb passed");
		end else begin
			$display("%0d mismatches, %0d results missing", fail_count, pending);
			$display("lidar_point_camera_projection_tb failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/lpcp_pkg.sv
rtl/lidar_point_camera_projection.sv
verif/lidar_point_camera_projection_chk.sv
verif/lidar_point_camera_projection_tb.sv
